>>> rtl/core/rqa_pkg.sv
// ----------------------------------------------------------------------------
// rqa_pkg
// Shared constants, types and helpers for the range quadratic add / range
// sum block.
// ----------------------------------------------------------------------------
package rqa_pkg;

    localparam int LENGTH_MAX = 1024;
    localparam int IDX_W      = 11;
    localparam int VAL_W      = 32;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = $clog2(LENGTH_MAX);
    localparam int LEN_W      = $clog2(LENGTH_MAX + 1);
    localparam int CMP_W      = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;
    localparam int LEN_RESET  = (LENGTH_MAX > 2047) ? 2047 : LENGTH_MAX;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_QADD = 2'd1,
        CMD_SUM  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic [DATA_W-1:0] range_sum;
        logic              bad_range;
    } result_t;

    function automatic logic [CMP_W-1:0] widen(input logic [IDX_W-1:0] idx);
        return {{(CMP_W - IDX_W){1'b0}}, idx};
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] t;
        t = widen(idx) - CMP_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic in_len(input logic [IDX_W-1:0] idx,
                                    input logic [IDX_W-1:0] len);
        return (widen(idx) <= widen(len)) && (widen(idx) <= CMP_W'(LENGTH_MAX));
    endfunction

endpackage

>>> rtl/core/range_quadratic_add_range_sum_tree.sv
// ----------------------------------------------------------------------------
// range_quadratic_add_range_sum_tree
// Range quadratic add and range sum over a cleared element array, with a
// length register and a registered result stage.
// ----------------------------------------------------------------------------
// Results: only range sums return a result, through the registered output
//   stage; load and range add return no result.
// Flow: one transaction is taken at a time; in_ready stays low until the
//   current one is done and any result handed over. Each walk is set by the
//   element store's single read and single write port, one element a cycle.
// Reset: clears all LENGTH_MAX elements, one per cycle, with in_ready low;
//   array_length resets to LENGTH_MAX.
module range_quadratic_add_range_sum_tree (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [rqa_pkg::IDX_W-1:0]   cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [rqa_pkg::IDX_W-1:0]   left_index,
    input  logic [rqa_pkg::IDX_W-1:0]   right_index,
    input  logic [rqa_pkg::VAL_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rqa_pkg::DATA_W-1:0]  range_sum,
    output logic                        bad_range
);

    logic [rqa_pkg::IDX_W-1:0] array_length_reg;
    logic                      out_valid_reg, out_valid_next;
    rqa_pkg::result_t          out_data_reg;
    logic                      res_valid;
    logic                      res_take;
    rqa_pkg::result_t          res;

    rqa_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .left_index   (left_index),
        .right_index  (right_index),
        .value        (value),
        .array_length (array_length_reg),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg <= rqa_pkg::IDX_W'(rqa_pkg::LEN_RESET);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                array_length_reg <= cfg_write_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign range_sum = out_data_reg.range_sum;
    assign bad_range = out_data_reg.bad_range;

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_take_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> !res_valid)
        else $error("result repeated after hand-over");

    a_bad_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_range) |-> (range_sum == '0))
        else $error("flagged range with non-zero sum");

endmodule

>>> rtl/core/rqa_elem_ram.sv
// ----------------------------------------------------------------------------
// rqa_elem_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rqa_elem_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [rqa_pkg::ADDR_W-1:0] waddr,
    input  logic [rqa_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [rqa_pkg::ADDR_W-1:0] raddr,
    output logic [rqa_pkg::DATA_W-1:0] rdata
);

    logic [rqa_pkg::DATA_W-1:0] mem [rqa_pkg::LENGTH_MAX];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/rqa_engine.sv
// ----------------------------------------------------------------------------
// rqa_engine
// Sequencer: clears the element store after reset, then walks each valid
// transaction's range, read-modify-write for loads and range adds.
// ----------------------------------------------------------------------------
module rqa_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [rqa_pkg::IDX_W-1:0]   left_index,
    input  logic [rqa_pkg::IDX_W-1:0]   right_index,
    input  logic [rqa_pkg::VAL_W-1:0]   value,
    input  logic [rqa_pkg::IDX_W-1:0]   array_length,
    output logic                        res_valid,
    input  logic                        res_take,
    output rqa_pkg::result_t            res
);

    rqa_pkg::state_e state_reg, state_next;

    logic [rqa_pkg::ADDR_W-1:0] clr_reg, clr_next;
    logic                       op_sum_reg, op_sum_next;
    logic [rqa_pkg::IDX_W-1:0]  cur_reg, cur_next;
    logic [rqa_pkg::IDX_W-1:0]  last_reg, last_next;
    logic                       iss_reg, iss_next;
    logic                       p1_reg, p1_next;
    logic [rqa_pkg::ADDR_W-1:0] p1_addr_reg, p1_addr_next;
    logic [rqa_pkg::DATA_W-1:0] delta_reg, delta_next;
    logic [rqa_pkg::DATA_W-1:0] step_reg, step_next;
    logic [rqa_pkg::DATA_W-1:0] w2_reg, w2_next;
    logic [rqa_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic                       bad_reg, bad_next;

    logic                       mem_we;
    logic [rqa_pkg::ADDR_W-1:0] mem_waddr;
    logic [rqa_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [rqa_pkg::ADDR_W-1:0] mem_raddr;
    logic [rqa_pkg::DATA_W-1:0] mem_rdata;

    logic                       in_fire;
    logic                       load_ok;
    logic                       range_ok;
    logic [rqa_pkg::DATA_W-1:0] w64;
    rqa_pkg::cmd_e              cmd;

    assign cmd      = rqa_pkg::cmd_e'(command);
    assign in_fire  = in_valid && in_ready;
    assign w64      = {{(rqa_pkg::DATA_W - rqa_pkg::VAL_W){value[rqa_pkg::VAL_W-1]}}, value};
    assign load_ok  = (left_index != '0) && rqa_pkg::in_len(left_index, array_length);
    assign range_ok = (left_index != '0) && (left_index <= right_index)
                      && rqa_pkg::in_len(right_index, array_length);

    rqa_elem_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rqa_pkg::ST_CLEAR:
            begin
                if (clr_reg == rqa_pkg::ADDR_W'(rqa_pkg::LENGTH_MAX - 1))
                begin
                    state_next = rqa_pkg::ST_IDLE;
                end
            end
            rqa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        rqa_pkg::CMD_LOAD:
                        begin
                            if (load_ok)
                            begin
                                state_next = rqa_pkg::ST_RUN;
                            end
                        end
                        rqa_pkg::CMD_QADD:
                        begin
                            if (range_ok)
                            begin
                                state_next = rqa_pkg::ST_RUN;
                            end
                        end
                        rqa_pkg::CMD_SUM:
                        begin
                            state_next = range_ok ? rqa_pkg::ST_RUN : rqa_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = rqa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rqa_pkg::ST_RUN:
            begin
                if (p1_reg && !iss_reg)
                begin
                    state_next = op_sum_reg ? rqa_pkg::ST_DONE : rqa_pkg::ST_IDLE;
                end
            end
            rqa_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = rqa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rqa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == rqa_pkg::ST_IDLE);
        res_valid = (state_reg == rqa_pkg::ST_DONE);
        res.range_sum = acc_reg;
        res.bad_range = bad_reg;
        mem_re    = (state_reg == rqa_pkg::ST_RUN) && iss_reg;
        mem_raddr = rqa_pkg::to_addr(cur_reg);
        if (state_reg == rqa_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == rqa_pkg::ST_RUN) && p1_reg && !op_sum_reg;
            mem_waddr = p1_addr_reg;
            mem_wdata = mem_rdata + delta_reg;
        end
    end

    // datapath
    always_comb
    begin
        clr_next     = clr_reg;
        op_sum_next  = op_sum_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        iss_next     = iss_reg;
        p1_next      = 1'b0;
        p1_addr_next = p1_addr_reg;
        delta_next   = delta_reg;
        step_next    = step_reg;
        w2_next      = w2_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        case (state_reg)
            rqa_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + rqa_pkg::ADDR_W'(1);
            end
            rqa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_sum_next = (cmd == rqa_pkg::CMD_SUM);
                    cur_next    = left_index;
                    last_next   = (cmd == rqa_pkg::CMD_LOAD) ? left_index : right_index;
                    iss_next    = 1'b1;
                    delta_next  = w64;
                    w2_next     = {w64[rqa_pkg::DATA_W-2:0], 1'b0};
                    step_next   = w64 + {w64[rqa_pkg::DATA_W-2:0], 1'b0};
                    acc_next    = '0;
                    bad_next    = (cmd == rqa_pkg::CMD_SUM) && !range_ok;
                end
            end
            rqa_pkg::ST_RUN:
            begin
                p1_next = iss_reg;
                if (iss_reg)
                begin
                    cur_next     = cur_reg + rqa_pkg::IDX_W'(1);
                    p1_addr_next = rqa_pkg::to_addr(cur_reg);
                    iss_next     = (cur_reg != last_reg);
                end
                if (p1_reg)
                begin
                    acc_next   = acc_reg + mem_rdata;
                    delta_next = delta_reg + step_reg;
                    step_next  = step_reg + w2_reg;
                end
            end
            default:
            begin
                p1_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqa_pkg::ST_CLEAR;
            clr_reg   <= '0;
            iss_reg   <= 1'b0;
            p1_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            iss_reg   <= iss_next;
            p1_reg    <= p1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_sum_reg  <= op_sum_next;
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        p1_addr_reg <= p1_addr_next;
        delta_reg   <= delta_next;
        step_reg    <= step_next;
        w2_reg      <= w2_next;
        acc_reg     <= acc_next;
        bad_reg     <= bad_next;
    end

endmodule

>>> dv/tb_range_quadratic_add_range_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_quadratic_add_range_sum_tree
// Drives loads, quadratic range adds and range sums into the block and
// compares every returned sum with a flat element-array predictor.
// Covers random sender gaps, receiver stalls and array length changes.
// ----------------------------------------------------------------------------
module tb_range_quadratic_add_range_sum_tree;

    typedef struct {
        logic [rqa_pkg::DATA_W-1:0] sum;
        logic                       bad;
    } sum_exp_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [rqa_pkg::IDX_W-1:0]  cfg_write_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 command;
    logic [rqa_pkg::IDX_W-1:0]  left_index;
    logic [rqa_pkg::IDX_W-1:0]  right_index;
    logic [rqa_pkg::VAL_W-1:0]  value;
    logic                       out_valid;
    logic                       out_ready;
    logic [rqa_pkg::DATA_W-1:0] range_sum;
    logic                       bad_range;

    logic [rqa_pkg::DATA_W-1:0] elem [0:2047];
    logic [rqa_pkg::IDX_W-1:0]  cur_length;
    sum_exp_t                   sum_queue[$];
    int                         error_count;
    int                         burst_left;
    int                         hold_cycles;
    bit                         ready_free;

    range_quadratic_add_range_sum_tree dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .left_index(left_index), .right_index(right_index),
        .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .range_sum(range_sum), .bad_range(bad_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 12000000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void predict_sum(input rqa_pkg::cmd_e cmd,
                                        input logic [rqa_pkg::IDX_W-1:0] l,
                                        input logic [rqa_pkg::IDX_W-1:0] r,
                                        input logic [rqa_pkg::VAL_W-1:0] v);
        logic [rqa_pkg::DATA_W-1:0] w;
        logic [rqa_pkg::DATA_W-1:0] d;
        logic [rqa_pkg::DATA_W-1:0] acc;
        int                         eff;
        bit                         ok;
        sum_exp_t                   e;
        w   = {{(rqa_pkg::DATA_W-rqa_pkg::VAL_W){v[rqa_pkg::VAL_W-1]}}, v};
        eff = (int'(cur_length) < rqa_pkg::LENGTH_MAX) ? int'(cur_length)
                                                       : rqa_pkg::LENGTH_MAX;
        ok  = (l >= 1) && (l <= r) && (int'(r) <= eff);
        case (cmd)
            rqa_pkg::CMD_LOAD:
                if (l >= 1 && int'(l) <= eff)
                    elem[l] = elem[l] + w;
            rqa_pkg::CMD_QADD:
                if (ok)
                    for (int i = l; i <= r; i++)
                    begin
                        d = rqa_pkg::DATA_W'(i - l + 1);
                        elem[i] = elem[i] + w * d * d;
                    end
            rqa_pkg::CMD_SUM:
            begin
                acc = '0;
                if (ok)
                    for (int i = l; i <= r; i++)
                        acc = acc + elem[i];
                e.sum = acc;
                e.bad = !ok;
                sum_queue.push_back(e);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input rqa_pkg::cmd_e cmd, input logic [rqa_pkg::IDX_W-1:0] l,
                             input logic [rqa_pkg::IDX_W-1:0] r,
                             input logic [rqa_pkg::VAL_W-1:0] v);
        bit ok;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        command     <= cmd;
        left_index  <= l;
        right_index <= r;
        value       <= v;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        while (!ok);
        predict_sum(cmd, l, r, v);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (rqa_pkg::LENGTH_MAX + 64) @(posedge clk);
    endtask

    task automatic write_length(input logic [rqa_pkg::IDX_W-1:0] len);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cur_length = len;
    endtask

    task automatic send_random(input int count);
        rqa_pkg::cmd_e             cmd;
        logic [rqa_pkg::IDX_W-1:0] l;
        logic [rqa_pkg::IDX_W-1:0] r;
        int                        pick;
        int                        span;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            cmd  = (pick < 35) ? rqa_pkg::CMD_LOAD : (pick < 65) ? rqa_pkg::CMD_QADD :
                   (pick < 97) ? rqa_pkg::CMD_SUM : rqa_pkg::CMD_NOP;
            pick = $urandom_range(0, 99);
            span = (pick < 90) ? $urandom_range(0, 15) :
                   (pick < 98) ? $urandom_range(16, 200) : 1023;
            l = rqa_pkg::IDX_W'($urandom_range(1, 1024 - span));
            r = rqa_pkg::IDX_W'(int'(l) + span);
            if ($urandom_range(0, 19) == 0)
            begin
                l = rqa_pkg::IDX_W'($urandom_range(0, 2047));
                r = rqa_pkg::IDX_W'($urandom_range(0, 2047));
            end
            send_item(cmd, l, r, $urandom());
        end
    endtask

    task automatic test_directed();
        send_item(rqa_pkg::CMD_SUM, 1, 1024, 0);
        send_item(rqa_pkg::CMD_LOAD, 1, 0, 32'h7fffffff);
        send_item(rqa_pkg::CMD_LOAD, 1024, 0, 32'h80000000);
        send_item(rqa_pkg::CMD_LOAD, 0, 0, 32'h12345678);
        send_item(rqa_pkg::CMD_LOAD, 1025, 0, 32'h12345678);
        send_item(rqa_pkg::CMD_LOAD, 2047, 2047, 32'hffffffff);
        send_item(rqa_pkg::CMD_SUM, 1, 1, 0);
        send_item(rqa_pkg::CMD_SUM, 1024, 1024, 0);
        send_item(rqa_pkg::CMD_QADD, 1, 1024, 32'h7fffffff);
        send_item(rqa_pkg::CMD_QADD, 1, 1024, 32'h80000000);
        send_item(rqa_pkg::CMD_QADD, 500, 520, 32'hffffffff);
        send_item(rqa_pkg::CMD_QADD, 9, 3, 32'h55);
        send_item(rqa_pkg::CMD_QADD, 0, 4, 32'h55);
        send_item(rqa_pkg::CMD_SUM, 1, 1024, 0);
        send_item(rqa_pkg::CMD_SUM, 490, 530, 0);
        send_item(rqa_pkg::CMD_SUM, 7, 6, 0);
        send_item(rqa_pkg::CMD_SUM, 0, 5, 0);
        send_item(rqa_pkg::CMD_SUM, 1000, 1025, 0);
        send_item(rqa_pkg::CMD_SUM, 2047, 2047, 0);
        send_item(rqa_pkg::CMD_NOP, 1, 1024, 32'haaaaaaaa);
        send_item(rqa_pkg::CMD_NOP, 2047, 0, 32'h55555555);
        send_item(rqa_pkg::CMD_SUM, 1, 1024, 0);
    endtask

    task automatic test_lengths();
        write_length(1);
        send_item(rqa_pkg::CMD_LOAD, 2, 0, 32'h11);
        send_item(rqa_pkg::CMD_QADD, 1, 2, 32'h3);
        send_item(rqa_pkg::CMD_SUM, 1, 2, 0);
        send_item(rqa_pkg::CMD_SUM, 1, 1, 0);
        send_random(60);
        write_length(0);
        send_item(rqa_pkg::CMD_LOAD, 1, 0, 32'h5);
        send_item(rqa_pkg::CMD_SUM, 1, 1, 0);
        send_random(20);
        write_length(2047);
        send_item(rqa_pkg::CMD_SUM, 1, 1024, 0);
        send_item(rqa_pkg::CMD_SUM, 1, 1025, 0);
        send_random(60);
        write_length(37);
        send_random(200);
        write_length(1024);
        send_item(rqa_pkg::CMD_SUM, 1, 1024, 0);
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_cycles = 3000;
        send_random(40);
        drain_results();
        send_random(40);
    endtask

    task automatic test_random();
        ready_free = 1'b1;
        send_random(300);
        ready_free = 1'b0;
        send_random(500);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (ready_free)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        sum_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (sum_queue.size() == 0)
            begin
                $display("%0t: unexpected result sum=%h bad=%b", $realtime,
                         range_sum, bad_range);
                error_count++;
            end
            else
            begin
                e = sum_queue.pop_front();
                if (range_sum !== e.sum)
                begin
                    $display("%0t: range_sum expected %h actual %h", $realtime,
                             e.sum, range_sum);
                    error_count++;
                end
                if (bad_range !== e.bad)
                begin
                    $display("%0t: bad_range expected %b actual %b", $realtime,
                             e.bad, bad_range);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        command        <= rqa_pkg::CMD_LOAD;
        left_index     <= '0;
        right_index    <= '0;
        value          <= '0;
        out_ready      <= 1'b0;
        hold_cycles    = 0;
        ready_free     = 1'b0;
        burst_left     = 0;
        error_count    = 0;
        cur_length     = rqa_pkg::IDX_W'(rqa_pkg::LENGTH_MAX);
        for (int i = 0; i < 2048; i++)
            elem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_lengths();
        send_random(250);
        drain_results();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
